// File: sv/gfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfba_pkg
// Shared types, codes and defaults for the grouped free-block allocator.
// ----------------------------------------------------------------------------
package gfba_pkg;

	localparam int GROUP_SIZE_DEF = 100;
	localparam int BLOCK_BITS_DEF = 24;

	// request codes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;
	localparam logic [1:0] OP_DRAIN = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOSPACE = 3'd1;
	localparam logic [2:0] ST_FILL    = 3'd2;
	localparam logic [2:0] ST_SPILL   = 3'd3;
	localparam logic [2:0] ST_REFUSED = 3'd4;

	// allocator modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_FILL  = 2'd1;
	localparam logic [1:0] MODE_DRAIN = 2'd2;

	// stack count updates
	localparam logic [2:0] CNT_HOLD  = 3'd0;
	localparam logic [2:0] CNT_DEC   = 3'd1;
	localparam logic [2:0] CNT_INC   = 3'd2;
	localparam logic [2:0] CNT_CLEAR = 3'd3;
	localparam logic [2:0] CNT_ONE   = 3'd4;
	localparam logic [2:0] CNT_TWO   = 3'd5;
	localparam logic [2:0] CNT_FILL  = 3'd6;

	// word index updates
	localparam logic [1:0] IDX_HOLD  = 2'd0;
	localparam logic [1:0] IDX_CLEAR = 2'd1;
	localparam logic [1:0] IDX_INC   = 2'd2;

	// write address select
	localparam logic [1:0] WA_COUNT = 2'd0;
	localparam logic [1:0] WA_IDXM1 = 2'd1;
	localparam logic [1:0] WA_ZERO  = 2'd2;
	localparam logic [1:0] WA_ONE   = 2'd3;

	// write data select
	localparam logic [2:0] WD_ZERO = 3'd0;
	localparam logic [2:0] WD_BLK  = 3'd1;
	localparam logic [2:0] WD_FILL = 3'd2;
	localparam logic [2:0] WD_PEND = 3'd3;
	localparam logic [2:0] WD_HELD = 3'd4;

	// read address select
	localparam logic RA_CNTM1 = 1'b0;
	localparam logic RA_IDXM1 = 1'b1;

	// target block select
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_BLK  = 2'd1;
	localparam logic [1:0] TGT_RD   = 2'd2;

	// drain word select
	localparam logic [1:0] DW_NONE  = 2'd0;
	localparam logic [1:0] DW_COUNT = 2'd1;
	localparam logic [1:0] DW_RD    = 2'd2;

	typedef struct packed {
		logic [2:0] cnt_op;
		logic [1:0] idx_op;
		logic       pend_blk;
		logic       pend_rd;
		logic       held_load;
		logic       mem_we;
		logic [1:0] wa_sel;
		logic [2:0] wd_sel;
		logic       rd_en;
		logic       ra_sel;
		logic       out_load;
		logic [2:0] res_status;
		logic       res_grant;
		logic [1:0] res_tgt;
		logic [1:0] res_word;
		logic       res_last;
	} gfba_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic idx_zero;
		logic idx_last;
		logic rd_zero;
	} gfba_sts_t;

endpackage
`default_nettype wire

// File: sv/grouped_free_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// Grouped free-list block allocator with an on-chip stack of free blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall) carries operation, block_number and
//   fill_word; a transfer happens on a clock edge with in_valid high and
//   in_stall low. Every request transfer yields exactly one result transfer on
//   the result channel (out_valid / out_stall): granted_block, status,
//   target_block, drain_word, drain_last.
//   Sequencing: free, fill word, refused requests, the count word of a drain and
//   allocate on an empty stack load the result register on acceptance. An allocate
//   that pops, a drain of a stack entry, and a free onto an empty stack pass
//   through a second state (stack read or second push), as set by the registered
//   read port and single write port of the stack RAM. One request is in flight
//   at a time: a new one is stalled until the last one has reached the result.
//   When status reports fill needed, feed GROUP_SIZE+1 fill words (count
//   first); when it reports spill needed, pull GROUP_SIZE+1 drain words and
//   write them into target_block. Other requests are refused meanwhile.
//   Reset (arst_n low) empties the stack and returns to idle mode; stack RAM
//   contents are not cleared. While the result receiver stalls, the result
//   holds and new requests are stalled until the result is taken.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator #(
	parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
	parameter int BLOCK_BITS = gfba_pkg::BLOCK_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [23:0] block_number,
	input  wire logic [23:0] fill_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [23:0] granted_block,
	output logic      [2:0]  status,
	output logic      [23:0] target_block,
	output logic      [23:0] drain_word,
	output logic             drain_last
);
	import gfba_pkg::*;

	// command and status between sequencer and datapath
	gfba_cmd_t cmd;
	gfba_sts_t sts;

	// sequencer: decode the request, track the mode, pace the RAM accesses
	gfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: stack RAM, count and index registers, result register
	gfba_dp #(
		.GROUP_SIZE(GROUP_SIZE),
		.BLOCK_BITS(BLOCK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.block_number (block_number),
		.fill_word    (fill_word),
		.granted_block(granted_block),
		.status       (status),
		.target_block (target_block),
		.drain_word   (drain_word),
		.drain_last   (drain_last)
	);

endmodule
`default_nettype wire

// File: sv/gfba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfba_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 100
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: sv/gfba_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfba_dp
// Datapath: stack RAM, stack count, word index, pending block, result regs.
// ----------------------------------------------------------------------------
module gfba_dp #(
	parameter int GROUP_SIZE = 100,
	parameter int BLOCK_BITS = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gfba_pkg::gfba_cmd_t cmd,
	output gfba_pkg::gfba_sts_t      sts,
	input  wire logic [23:0]         block_number,
	input  wire logic [23:0]         fill_word,
	output logic      [23:0]         granted_block,
	output logic      [2:0]          status,
	output logic      [23:0]         target_block,
	output logic      [23:0]         drain_word,
	output logic                     drain_last
);
	import gfba_pkg::*;

	localparam int CW = $clog2(GROUP_SIZE + 1);
	localparam int AW = $clog2(GROUP_SIZE);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [BLOCK_BITS-1:0] pend_q;
	logic [BLOCK_BITS-1:0] held_q;
	logic [BLOCK_BITS-1:0] blk_w;
	logic [BLOCK_BITS-1:0] fill_w;
	logic [BLOCK_BITS-1:0] rd_data;
	logic [BLOCK_BITS-1:0] wr_data;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         idx_m1;
	logic [CW-1:0]         fill_cnt;

	// keep block values to BLOCK_BITS
	assign blk_w  = BLOCK_BITS'(block_number);
	assign fill_w = BLOCK_BITS'(fill_word);
	assign cnt_m1 = count_q - CW'(1);
	assign idx_m1 = idx_q - CW'(1);

	// clamp the group count word
	assign fill_cnt = (fill_word > 24'(GROUP_SIZE)) ? CW'(GROUP_SIZE) : CW'(fill_word);

	assign sts.count_zero = (count_q == '0);
	assign sts.count_full = (count_q >= CW'(GROUP_SIZE));
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.idx_last   = (idx_q >= CW'(GROUP_SIZE));
	assign sts.rd_zero    = (rd_data == '0);

	always_comb begin
		unique case (cmd.wa_sel)
			WA_COUNT: wr_addr = count_q[AW-1:0];
			WA_IDXM1: wr_addr = idx_m1[AW-1:0];
			WA_ZERO:  wr_addr = AW'(0);
			WA_ONE:   wr_addr = AW'(1);
			default:  wr_addr = AW'(0);
		endcase
		unique case (cmd.wd_sel)
			WD_ZERO: wr_data = '0;
			WD_BLK:  wr_data = blk_w;
			WD_FILL: wr_data = fill_w;
			WD_PEND: wr_data = pend_q;
			WD_HELD: wr_data = held_q;
			default: wr_data = '0;
		endcase
		rd_addr = (cmd.ra_sel == RA_IDXM1) ? idx_m1[AW-1:0] : cnt_m1[AW-1:0];
	end

	gfba_ram #(
		.WIDTH(BLOCK_BITS),
		.DEPTH(GROUP_SIZE)
	) u_stack (
		.clk    (clk),
		.we     (cmd.mem_we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_HOLD:  count_q <= count_q;
				CNT_DEC:   count_q <= cnt_m1;
				CNT_INC:   count_q <= count_q + CW'(1);
				CNT_CLEAR: count_q <= '0;
				CNT_ONE:   count_q <= CW'(1);
				CNT_TWO:   count_q <= CW'(2);
				CNT_FILL:  count_q <= fill_cnt;
				default:   count_q <= count_q;
			endcase
			unique case (cmd.idx_op)
				IDX_HOLD:  idx_q <= idx_q;
				IDX_CLEAR: idx_q <= '0;
				IDX_INC:   idx_q <= idx_q + CW'(1);
				default:   idx_q <= idx_q;
			endcase
			if (cmd.pend_blk) begin
				pend_q <= blk_w;
			end else if (cmd.pend_rd) begin
				pend_q <= rd_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.held_load) begin
			held_q <= blk_w;
		end
		if (cmd.out_load) begin
			status        <= cmd.res_status;
			granted_block <= cmd.res_grant ? 24'(rd_data) : '0;
			drain_last    <= cmd.res_last;
			unique case (cmd.res_tgt)
				TGT_NONE: target_block <= '0;
				TGT_BLK:  target_block <= 24'(blk_w);
				TGT_RD:   target_block <= 24'(rd_data);
				default:  target_block <= '0;
			endcase
			unique case (cmd.res_word)
				DW_NONE:  drain_word <= '0;
				DW_COUNT: drain_word <= 24'(count_q);
				DW_RD:    drain_word <= 24'(rd_data);
				default:  drain_word <= '0;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/gfba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfba_ctrl
// Controller: request decode, allocator mode, sequencing and result valid.
// ----------------------------------------------------------------------------
module gfba_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          operation,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire gfba_pkg::gfba_sts_t sts,
	output gfba_pkg::gfba_cmd_t      cmd
);
	import gfba_pkg::*;

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_ALLOC_RD = 2'd1;
	localparam logic [1:0] S_DRAIN_RD = 2'd2;
	localparam logic [1:0] S_PUSH2    = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic       out_valid_q;
	logic       slot_free;
	logic       acc;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && slot_free);
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.cnt_op     = CNT_HOLD;
		cmd.idx_op     = IDX_HOLD;
		cmd.res_status = ST_OK;
		cmd.res_tgt    = TGT_NONE;
		cmd.res_word   = DW_NONE;
		state_d        = state_q;
		mode_d         = mode_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.out_load = 1'b1;
					unique case (operation)
						OP_ALLOC: begin
							if (mode_q != MODE_IDLE) begin
								cmd.res_status = ST_REFUSED;
							end else if (sts.count_zero) begin
								cmd.res_status = ST_NOSPACE;
							end else begin
								cmd.out_load = 1'b0;
								cmd.cnt_op   = CNT_DEC;
								cmd.rd_en    = 1'b1;
								cmd.ra_sel   = RA_CNTM1;
								state_d      = S_ALLOC_RD;
							end
						end
						OP_FREE: begin
							if (mode_q != MODE_IDLE) begin
								cmd.res_status = ST_REFUSED;
							end else if (sts.count_zero) begin
								// lay down the end sentinel, push next cycle
								cmd.out_load  = 1'b0;
								cmd.mem_we    = 1'b1;
								cmd.wa_sel    = WA_ZERO;
								cmd.wd_sel    = WD_ZERO;
								cmd.held_load = 1'b1;
								state_d       = S_PUSH2;
							end else if (sts.count_full) begin
								mode_d         = MODE_DRAIN;
								cmd.idx_op     = IDX_CLEAR;
								cmd.pend_blk   = 1'b1;
								cmd.res_status = ST_SPILL;
								cmd.res_tgt    = TGT_BLK;
							end else begin
								cmd.mem_we = 1'b1;
								cmd.wa_sel = WA_COUNT;
								cmd.wd_sel = WD_BLK;
								cmd.cnt_op = CNT_INC;
							end
						end
						OP_FILL: begin
							if (mode_q != MODE_FILL) begin
								cmd.res_status = ST_REFUSED;
							end else begin
								if (sts.idx_zero) begin
									cmd.cnt_op = CNT_FILL;
								end else begin
									cmd.mem_we = 1'b1;
									cmd.wa_sel = WA_IDXM1;
									cmd.wd_sel = WD_FILL;
								end
								cmd.res_last = sts.idx_last;
								if (sts.idx_last) begin
									mode_d     = MODE_IDLE;
									cmd.idx_op = IDX_CLEAR;
								end else begin
									cmd.idx_op = IDX_INC;
								end
							end
						end
						OP_DRAIN: begin
							if (mode_q != MODE_DRAIN) begin
								cmd.res_status = ST_REFUSED;
							end else if (sts.idx_zero) begin
								cmd.res_word = DW_COUNT;
								cmd.idx_op   = IDX_INC;
							end else begin
								cmd.out_load = 1'b0;
								cmd.rd_en    = 1'b1;
								cmd.ra_sel   = RA_IDXM1;
								state_d      = S_DRAIN_RD;
							end
						end
					endcase
				end
			end
			S_ALLOC_RD: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
				if (sts.rd_zero) begin
					cmd.cnt_op     = CNT_CLEAR;
					cmd.res_status = ST_NOSPACE;
				end else if (sts.count_zero) begin
					mode_d         = MODE_FILL;
					cmd.idx_op     = IDX_CLEAR;
					cmd.pend_rd    = 1'b1;
					cmd.res_status = ST_FILL;
					cmd.res_grant  = 1'b1;
					cmd.res_tgt    = TGT_RD;
				end else begin
					cmd.res_grant = 1'b1;
				end
			end
			S_DRAIN_RD: begin
				cmd.out_load = 1'b1;
				cmd.res_word = DW_RD;
				cmd.res_last = sts.idx_last;
				state_d      = S_IDLE;
				if (sts.idx_last) begin
					// restart the stack with the spill block
					cmd.mem_we = 1'b1;
					cmd.wa_sel = WA_ZERO;
					cmd.wd_sel = WD_PEND;
					cmd.cnt_op = CNT_ONE;
					cmd.idx_op = IDX_CLEAR;
					mode_d     = MODE_IDLE;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			S_PUSH2: begin
				cmd.mem_we   = 1'b1;
				cmd.wa_sel   = WA_ONE;
				cmd.wd_sel   = WD_HELD;
				cmd.cnt_op   = CNT_TWO;
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// an accepted allocate on a non-empty stack in idle mode always goes through the stack read
	a_alloc_read: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && operation == OP_ALLOC && mode_q == MODE_IDLE && !sts.count_zero)
		|=> (state_q == S_ALLOC_RD))
		else $error("allocate skipped stack read");

	// fill mode ends only after the last fill word
	a_fill_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_FILL) ##1 (mode_q == MODE_IDLE) |-> $past(sts.idx_last))
		else $error("fill mode left early");

	// drain mode ends only after the last drain word
	a_drain_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DRAIN) ##1 (mode_q == MODE_IDLE) |-> $past(sts.idx_last))
		else $error("drain mode left early");

endmodule
`default_nettype wire
